FILE: rtl/pse_pkg.sv
package pse_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_RECT  = 2'd2;

  // Event sources.
  localparam logic [1:0] SRC_MOUSE  = 2'd0;
  localparam logic [1:0] SRC_PEN    = 2'd1;
  localparam logic [1:0] SRC_ERASER = 2'd2;
  localparam logic [1:0] SRC_CURSOR = 2'd3;

  // Request types.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DRAW  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEFAULT_THICK = 2'd0;
  localparam logic [1:0] CFG_PRESSURE_MAX  = 2'd1;
  localparam logic [1:0] CFG_SAFE_RADIUS   = 2'd2;

  // Quotient bits of the offset divider. The offset never exceeds a sixteenth
  // of the half-width plus rounding, so 14 bits always hold it.
  localparam int unsigned QW = 14;

  typedef struct packed {
    logic       accept;
    logic       hw_upd;
    logic       sqy;
    logic       root_init;
    logic       root_step;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       corner;
    logic       box;
    logic       rect;
    logic       out_ld;
    logic [1:0] out_kind;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic root_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/pse_ctrl.sv
module pse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          req_type_i,
  output logic          in_stall_o,
  input  pse_pkg::sts_t sts_i,
  output pse_pkg::cmd_t cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_HW     = 15'b000000000000010,
    S_SQY    = 15'b000000000000100,
    S_RINIT  = 15'b000000000001000,
    S_ROOT   = 15'b000000000010000,
    S_MUL    = 15'b000000000100000,
    S_DINIT  = 15'b000000001000000,
    S_DIV    = 15'b000000010000000,
    S_CORNER = 15'b000000100000000,
    S_BOX    = 15'b000001000000000,
    S_RECT   = 15'b000010000000000,
    S_OUT0   = 15'b000100000000000,
    S_OUT1   = 15'b001000000000000,
    S_OUT2   = 15'b010000000000000,
    S_SPARE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (req_type_i == pse_pkg::REQ_DRAW) begin
            state_d = S_HW;
          end
        end
      end
      S_HW: begin
        cmd_o.hw_upd = 1'b1;
        state_d = sts_i.zero ? S_IDLE : S_SQY;
      end
      S_SQY: begin
        cmd_o.sqy = 1'b1;
        state_d = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.root_init = 1'b1;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_CORNER;
        end
      end
      S_CORNER: begin
        cmd_o.corner = 1'b1;
        state_d = S_BOX;
      end
      S_BOX: begin
        cmd_o.box = 1'b1;
        state_d = S_RECT;
      end
      S_RECT: begin
        cmd_o.rect = 1'b1;
        state_d = S_OUT0;
      end
      S_OUT0: begin
        cmd_o.out_kind = pse_pkg::KIND_START;
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d = S_OUT1;
        end
      end
      S_OUT1: begin
        cmd_o.out_kind = pse_pkg::KIND_END;
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d = S_OUT2;
        end
      end
      S_OUT2: begin
        cmd_o.out_kind = pse_pkg::KIND_RECT;
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/pse_dp.sv
module pse_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               req_type_i,
  input  logic [1:0]         source_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic [15:0]        pen_pressure_i,
  input  pse_pkg::cmd_t      cmd_i,
  output pse_pkg::sts_t      sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         kind_o,
  output logic signed [23:0] a_x_o,
  output logic signed [23:0] a_y_o,
  output logic signed [23:0] b_x_o,
  output logic signed [23:0] b_y_o,
  output logic               first_cap_o,
  output logic               last_o
);

  localparam int unsigned QW = pse_pkg::QW;

  // Configuration.
  logic [15:0] dflt_q, pmax_q, srad_q;

  // Stroke state.
  logic signed [23:0] prev_x_q, prev_y_q, pl_x_q, pl_y_q, pr_x_q, pr_y_q;
  logic               first_pend_q;
  logic [15:0]        hw_q;

  // Latched event.
  logic signed [23:0] x_q, y_q;
  logic [1:0]         src_q;
  logic [15:0]        pp_q;
  logic signed [24:0] dx_q, dy_q;

  // Length and offset units.
  logic [48:0] sqx_q, sqy_q;
  logic [61:0] rad_q, root_q, bit_q;
  logic [40:0] prodx_q, prody_q;
  logic [31:0] remx_q, remy_q;
  logic [QW-1:0] lowx_q, lowy_q;
  logic [3:0]  div_cnt_q;

  // Corners, box and rectangle.
  logic signed [23:0] l1x_q, l1y_q, r1x_q, r1y_q, l2x_q, l2y_q, r2x_q, r2y_q;
  logic signed [23:0] mnx_q, mny_q, mxx_q, mxy_q;
  logic signed [23:0] rx_q, ry_q, rw_q, rh_q;

  // Output register.
  logic               out_valid_q;
  logic [1:0]         kind_q;
  logic signed [23:0] ax_q, ay_q, bx_q, by_q;
  logic               cap_q, last_q;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [25:0] ext26(input logic signed [23:0] v);
    return {{2{v[23]}}, v};
  endfunction

  function automatic logic signed [23:0] min2(input logic signed [23:0] a,
                                              input logic signed [23:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [23:0] max2(input logic signed [23:0] a,
                                              input logic signed [23:0] b);
    return (a > b) ? a : b;
  endfunction

  // One restoring division step: returns the new remainder and shifted low word.
  function automatic logic [32+QW-1:0] div_step(input logic [31:0]   rem,
                                                input logic [QW-1:0] low,
                                                input logic [31:0]   dvs);
    logic [32:0]   t;
    logic [31:0]   nrem;
    logic          qb;
    t = {rem, low[QW-1]};
    if (t >= {1'b0, dvs}) begin
      nrem = 32'(t - {1'b0, dvs});
      qb   = 1'b1;
    end else begin
      nrem = t[31:0];
      qb   = 1'b0;
    end
    return {nrem, low[QW-2:0], qb};
  endfunction

  logic [24:0] adx, ady;
  logic [30:0] len;
  logic [31:0] dvs;
  logic [44:0] numx, numy;
  logic [61:0] trial;
  logic [32+QW-1:0] stepx, stepy;
  logic signed [15:0] ox, oy;
  logic signed [25:0] vx, vy, spx, spy;

  always_comb begin
    adx   = dx_q[24] ? 25'(-dx_q) : 25'(dx_q);
    ady   = dy_q[24] ? 25'(-dy_q) : 25'(dy_q);
    len   = root_q[30:0];
    dvs   = {len, 1'b0};
    // Numerator 2*|c|*hw*4 plus len gives round-half-away after division by 2*len.
    numx  = {1'b0, prodx_q, 3'b000} + 45'(len);
    numy  = {1'b0, prody_q, 3'b000} + 45'(len);
    trial = root_q + bit_q;
    stepx = div_step(remx_q, lowx_q, dvs);
    stepy = div_step(remy_q, lowy_q, dvs);
    // x offset is the scaled -dy, so it is negative when dy is positive.
    ox    = !dy_q[24] ? -$signed({2'b00, lowx_q}) : $signed({2'b00, lowx_q});
    oy    = dx_q[24]  ? -$signed({2'b00, lowy_q}) : $signed({2'b00, lowy_q});
    vx    = ext26(mnx_q) - $signed({10'd0, srad_q});
    vy    = ext26(mny_q) - $signed({10'd0, srad_q});
    spx   = ext26(mxx_q) - ext26(mnx_q) + $signed({9'd0, srad_q, 1'b0});
    spy   = ext26(mxy_q) - ext26(mny_q) + $signed({9'd0, srad_q, 1'b0});
  end

  assign sts_o.zero      = (dx_q == '0) && (dy_q == '0);
  assign sts_o.root_last = bit_q[0];
  assign sts_o.div_last  = (div_cnt_q == 4'(QW - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Configuration and stroke state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q       <= 16'd8192;
      pmax_q       <= 16'd8192;
      srad_q       <= 16'd1024;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      pl_x_q       <= '0;
      pl_y_q       <= '0;
      pr_x_q       <= '0;
      pr_y_q       <= '0;
      first_pend_q <= 1'b0;
      hw_q         <= 16'd8192;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pse_pkg::CFG_DEFAULT_THICK: dflt_q <= cfg_data_i;
          pse_pkg::CFG_PRESSURE_MAX:  pmax_q <= cfg_data_i;
          pse_pkg::CFG_SAFE_RADIUS:   srad_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.accept && (req_type_i == pse_pkg::REQ_START)) begin
        prev_x_q     <= pos_x_i;
        prev_y_q     <= pos_y_i;
        first_pend_q <= 1'b1;
      end
      if (cmd_i.hw_upd) begin
        case (src_q)
          pse_pkg::SRC_MOUSE:  hw_q <= dflt_q;
          pse_pkg::SRC_PEN,
          pse_pkg::SRC_ERASER: hw_q <= 16'((32'(pmax_q) * 32'(pp_q)) >> 16);
          default: begin
          end
        endcase
      end
      if (cmd_i.commit) begin
        prev_x_q     <= x_q;
        prev_y_q     <= y_q;
        pl_x_q       <= l2x_q;
        pl_y_q       <= l2y_q;
        pr_x_q       <= r2x_q;
        pr_y_q       <= r2y_q;
        first_pend_q <= 1'b0;
      end
    end
  end

  // Arithmetic datapath.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      src_q <= source_i;
      pp_q  <= 16'((32'(pen_pressure_i) * 32'(pen_pressure_i)) >> 16);
      dx_q  <= 25'(pos_x_i) - 25'(prev_x_q);
      dy_q  <= 25'(pos_y_i) - 25'(prev_y_q);
    end
    if (cmd_i.hw_upd) begin
      sqx_q <= 49'(adx) * 49'(adx);
    end
    if (cmd_i.sqy) begin
      sqy_q <= 49'(ady) * 49'(ady);
    end
    if (cmd_i.root_init) begin
      rad_q  <= {50'(sqx_q) + 50'(sqy_q), 12'd0};
      root_q <= '0;
      bit_q  <= 62'd1 << 60;
    end
    if (cmd_i.root_step) begin
      if (rad_q >= trial) begin
        rad_q  <= rad_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.mul) begin
      prodx_q <= 41'(ady) * 41'(hw_q);
      prody_q <= 41'(adx) * 41'(hw_q);
    end
    if (cmd_i.div_init) begin
      remx_q    <= 32'(numx >> QW);
      remy_q    <= 32'(numy >> QW);
      lowx_q    <= numx[QW-1:0];
      lowy_q    <= numy[QW-1:0];
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      remx_q    <= stepx[32+QW-1:QW];
      lowx_q    <= stepx[QW-1:0];
      remy_q    <= stepy[32+QW-1:QW];
      lowy_q    <= stepy[QW-1:0];
      div_cnt_q <= div_cnt_q + 4'd1;
    end
    if (cmd_i.corner) begin
      l2x_q <= sat24(ext26(x_q) + 26'(ox));
      l2y_q <= sat24(ext26(y_q) + 26'(oy));
      r2x_q <= sat24(ext26(x_q) - 26'(ox));
      r2y_q <= sat24(ext26(y_q) - 26'(oy));
      if (first_pend_q) begin
        l1x_q <= sat24(ext26(prev_x_q) + 26'(ox));
        l1y_q <= sat24(ext26(prev_y_q) + 26'(oy));
        r1x_q <= sat24(ext26(prev_x_q) - 26'(ox));
        r1y_q <= sat24(ext26(prev_y_q) - 26'(oy));
      end else begin
        l1x_q <= pl_x_q;
        l1y_q <= pl_y_q;
        r1x_q <= pr_x_q;
        r1y_q <= pr_y_q;
      end
    end
    if (cmd_i.box) begin
      mnx_q <= min2(min2(l1x_q, r1x_q), min2(l2x_q, r2x_q));
      mny_q <= min2(min2(l1y_q, r1y_q), min2(l2y_q, r2y_q));
      mxx_q <= max2(max2(l1x_q, r1x_q), max2(l2x_q, r2x_q));
      mxy_q <= max2(max2(l1y_q, r1y_q), max2(l2y_q, r2y_q));
    end
    if (cmd_i.rect) begin
      // Division by 256 truncating toward zero: bias negative values first.
      rx_q <= 24'((vx + (vx[25] ? 26'sd255 : 26'sd0)) >>> 8);
      ry_q <= 24'((vy + (vy[25] ? 26'sd255 : 26'sd0)) >>> 8);
      rw_q <= 24'((spx >>> 8) + 26'sd1);
      rh_q <= 24'((spy >>> 8) + 26'sd1);
    end
    if (cmd_i.out_ld) begin
      kind_q <= cmd_i.out_kind;
      cap_q  <= first_pend_q;
      last_q <= (cmd_i.out_kind == pse_pkg::KIND_RECT);
      case (cmd_i.out_kind)
        pse_pkg::KIND_START: begin
          ax_q <= l1x_q;
          ay_q <= l1y_q;
          bx_q <= r1x_q;
          by_q <= r1y_q;
        end
        pse_pkg::KIND_END: begin
          ax_q <= l2x_q;
          ay_q <= l2y_q;
          bx_q <= r2x_q;
          by_q <= r2y_q;
        end
        default: begin
          ax_q <= rx_q;
          ay_q <= ry_q;
          bx_q <= rw_q;
          by_q <= rh_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign a_x_o       = ax_q;
  assign a_y_o       = ay_q;
  assign b_x_o       = bx_q;
  assign b_y_o       = by_q;
  assign first_cap_o = cap_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> (root_q[61:31] == '0))
    else $error("segment length exceeds 31 bits");

  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.corner |-> (lowx_q[QW-1] == 1'b0) && (lowy_q[QW-1] == 1'b0))
    else $error("offset quotient overflow");

  a_commit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !sts_o.zero)
    else $error("zero-length segment committed");

  a_rect_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld && (cmd_i.out_kind == pse_pkg::KIND_RECT) |->
      !rw_q[23] && !rh_q[23] && (rw_q != '0) && (rh_q != '0))
    else $error("dirty rectangle size not positive");
`endif

endmodule

FILE: rtl/pen_stroke_segment_expander.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o req_type, source, pos_x, pos_y, pen_pressure
// out       output     out_valid_o / out_stall_i kind, a_x, a_y, b_x, b_y, first_cap, last
// cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// A start event is accepted in the idle state and stays there; a zero-length draw
// event returns to idle from the half-width state. A drawn segment passes the
// 31-step square root and the 14-step offset divider, then gives three results.
// Input transfers are taken only while the controller is idle; the last
// result may still wait in the output register while the next event enters.
// Reset is asynchronous and active low; it loads the register defaults.
module pen_stroke_segment_expander (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [1:0]         source_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic [15:0]        pen_pressure_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [23:0] a_x_o,
  output logic signed [23:0] a_y_o,
  output logic signed [23:0] b_x_o,
  output logic signed [23:0] b_y_o,
  output logic               first_cap_o,
  output logic               last_o
);

  pse_pkg::cmd_t cmd;
  pse_pkg::sts_t sts;

  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pse_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .source_i       (source_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pen_pressure_i (pen_pressure_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .a_x_o          (a_x_o),
    .a_y_o          (a_y_o),
    .b_x_o          (b_x_o),
    .b_y_o          (b_y_o),
    .first_cap_o    (first_cap_o),
    .last_o         (last_o)
  );

endmodule
